>>> src/assert_macros.svh
// Assertion macros shared by the RTL of this project.
// No dependencies; ASSERT_OFF removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

>>> src/dmwp_pkg.sv
// Package for the depth back-projection core: widths, register indexes,
// reset values and the output saturation function. No dependencies.
package dmwp_pkg;

  localparam int DEF_MAX_DIM = 4096;

  localparam int DEPTH_W    = 16;
  localparam int WORLD_W    = 24;
  localparam int DIM_W      = 13;
  localparam int CENTER_W   = 16;
  localparam int INV_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd5;

  localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 13'd480;
  localparam logic [CENTER_W-1:0] RST_CENTER_X     = 16'd5120;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 16'd3840;
  localparam logic [INV_W-1:0]    RST_INV_FOCAL    = 32'd8180917;

  typedef logic signed [WORLD_W-1:0] world_t;

  // Clamp a magnitude to the 24-bit signed range and apply the sign.
  function automatic world_t saturate(input logic [63:0] q, input logic neg);
    logic [63:0] lim;
    logic [WORLD_W-1:0] m;
    begin
      lim = neg ? 64'h80_0000 : 64'h7F_FFFF;
      m   = (q > lim) ? lim[WORLD_W-1:0] : q[WORLD_W-1:0];
      saturate = neg ? world_t'(-m) : world_t'(m);
    end
  endfunction

endpackage

>>> src/depth_map_to_world_points_core.sv
// Depth back-projection core: turns raster-order depth samples into world X/Y.
// Depends on dmwp_pkg and assert_macros.svh.
//
// Input channel: in_valid/in_ready with one depth sample per item, raster
// order. Output channel: out_valid/out_ready with depth_out, world_x, world_y
// and frame_end (high on the last pixel of the frame).
// Configuration: cfg_write/cfg_index/cfg_data, taken on any edge with
// cfg_write high; write only while the core is idle.
// One 32x32 multiplier is shared under a small sequencer: per axis one
// step for offset*depth and one for the product with the reciprocal focal
// length (a second partial product when MAX_DIM pushes that product past
// 32 bits). The core takes no new item until the result of the last one
// has moved into the output register. The output register holds a result
// while the receiver stalls; the core takes the next item meanwhile and
// waits only when a second result is ready to leave. Reset restores the
// register defaults and clears the column and row counters and the output
// valid flag; in_ready stays low while rst is high.
module depth_map_to_world_points_core #(
  parameter int MAX_DIM = dmwp_pkg::DEF_MAX_DIM
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [dmwp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dmwp_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [dmwp_pkg::DEPTH_W-1:0]   depth,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dmwp_pkg::DEPTH_W-1:0]   depth_out,
  output logic signed [dmwp_pkg::WORLD_W-1:0]   world_x,
  output logic signed [dmwp_pkg::WORLD_W-1:0]   world_y,
  output logic                                  frame_end
);
  import dmwp_pkg::*;

  localparam int CW       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CMPW     = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int SCW      = CW + 5;
  localparam int DLW      = ((SCW > CENTER_W) ? SCW : CENTER_W) + 1;
  localparam int DW       = DLW - 1;
  localparam int PW       = DW + DEPTH_W;
  localparam bit TWO_PASS = (PW > 32);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAG  = 3'd1;
  localparam logic [2:0] ST_LO   = 3'd2;
  localparam logic [2:0] ST_HI   = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [DIM_W-1:0]    frame_width, frame_height;
  logic [CENTER_W-1:0] center_x, center_y;
  logic [INV_W-1:0]    inv_focal_x, inv_focal_y;

  logic [CW-1:0] column, row, pos_x, pos_y;
  logic [2:0]    state;
  logic          axis;
  logic          neg;
  logic          end_flag;
  logic signed [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] mag_z;
  logic [PW-1:0]      prod;
  logic [31:0]        acc;
  world_t             res_x, res_y;

  logic [CMPW-1:0] w_eff, h_eff, col_inc, row_inc;
  logic            last_col, last_row;
  logic [CW-1:0]   pos_sel;
  logic [CENTER_W-1:0] ctr_sel;
  logic [SCW-1:0]  pos_scaled;
  logic [DLW-1:0]  delta;
  logic [DW-1:0]   mag_d;
  logic [DEPTH_W:0] depth_neg;
  logic [63:0]     prod_ext;
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     mul_p;
  logic [63:0]     q;
  world_t          res_new;

  // Frame geometry and counter wrap
  always_comb begin
    w_eff = (frame_width == '0) ? CMPW'(1) :
            ((CMPW'(frame_width) > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : CMPW'(frame_width));
    h_eff = (frame_height == '0) ? CMPW'(1) :
            ((CMPW'(frame_height) > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : CMPW'(frame_height));
    col_inc  = CMPW'(column) + CMPW'(1);
    row_inc  = CMPW'(row) + CMPW'(1);
    last_col = (col_inc >= w_eff);
    last_row = (row_inc >= h_eff);
    depth_neg = -{depth[DEPTH_W-1], depth};
  end

  // Offset of the pixel from the principal point, in sixteenths
  always_comb begin
    pos_sel    = axis ? pos_y : pos_x;
    ctr_sel    = axis ? center_y : center_x;
    pos_scaled = {(CW + 1)'(pos_sel) + (CW + 1)'(1), 4'b0000};
    delta      = DLW'(pos_scaled) - DLW'(ctr_sel);
    mag_d      = delta[DLW-1] ? DW'(-delta) : delta[DW-1:0];
    prod_ext   = 64'(prod);
  end

  // Shared multiplier
  always_comb begin
    mul_a = 32'(mag_d);
    mul_b = 32'(mag_z);
    case (state)
      ST_MAG: begin
        mul_a = 32'(mag_d);
        mul_b = 32'(mag_z);
      end
      ST_LO: begin
        mul_a = prod_ext[31:0];
        mul_b = axis ? inv_focal_y : inv_focal_x;
      end
      ST_HI: begin
        mul_a = prod_ext[63:32];
        mul_b = axis ? inv_focal_y : inv_focal_x;
      end
      default: begin
        mul_a = 32'(mag_d);
        mul_b = 32'(mag_z);
      end
    endcase
    mul_p = mul_a * mul_b;
    if (state == ST_HI) begin
      q = (mul_p + 64'(acc)) >> 4;
    end else begin
      q = mul_p >> 36;
    end
    res_new = saturate(q, neg);
  end

  assign in_ready = !rst && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      center_x     <= RST_CENTER_X;
      center_y     <= RST_CENTER_Y;
      inv_focal_x  <= RST_INV_FOCAL;
      inv_focal_y  <= RST_INV_FOCAL;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        REG_CENTER_X:     center_x     <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:     center_y     <= cfg_data[CENTER_W-1:0];
        REG_INV_FOCAL_X:  inv_focal_x  <= cfg_data[INV_W-1:0];
        REG_INV_FOCAL_Y:  inv_focal_y  <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= 1'b0;
      column    <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      // the output step reloads out_valid itself
      if (out_valid && out_ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            depth_r  <= depth;
            mag_z    <= depth[DEPTH_W-1] ? depth_neg[DEPTH_W-1:0] : depth;
            pos_x    <= column;
            pos_y    <= row;
            end_flag <= last_col && last_row;
            axis     <= 1'b0;
            if (last_col) begin
              column <= '0;
              row    <= last_row ? '0 : row_inc[CW-1:0];
            end else begin
              column <= col_inc[CW-1:0];
            end
            state <= ST_MAG;
          end
        end
        ST_MAG: begin
          prod  <= mul_p[PW-1:0];
          neg   <= delta[DLW-1] ^ depth_r[DEPTH_W-1] ^ axis;
          state <= ST_LO;
        end
        ST_LO: begin
          if (TWO_PASS) begin
            acc   <= mul_p[63:32];
            state <= ST_HI;
          end else begin
            if (axis) res_y <= res_new;
            else      res_x <= res_new;
            axis  <= 1'b1;
            state <= axis ? ST_OUT : ST_MAG;
          end
        end
        ST_HI: begin
          if (axis) res_y <= res_new;
          else      res_x <= res_new;
          axis  <= 1'b1;
          state <= axis ? ST_OUT : ST_MAG;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            depth_out <= depth_r;
            world_x   <= res_x;
            world_y   <= res_y;
            frame_end <= end_flag;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"

  `ASSERT_CLK(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready, "core took an item while busy")
  `ASSERT_CLK(a_load_from_out, clk, rst, $rose(out_valid) |-> $past(state == ST_OUT), "result raised outside the output step")
  `ASSERT_NEVER(a_column_range, clk, rst, CMPW'(column) >= CMPW'(MAX_DIM), "column counter out of range")

endmodule
